FILE: rtl/lcdfi_pkg.sv
// shared types, constants and register map of the lcd frame interrupt block
// no dependencies; used by every module under rtl
package lcdfi_pkg;

   localparam int WINDOW_COUNT = 4;
   localparam int WIN_WORDS    = 6;
   localparam int WIN_STRIDE   = 24;
   localparam int WIN_ENTRIES  = WINDOW_COUNT * WIN_WORDS;
   localparam int WIN_SPAN     = WINDOW_COUNT * WIN_STRIDE;
   localparam int WIN_IDX_W    = (WIN_ENTRIES > 1) ? $clog2(WIN_ENTRIES) : 1;
   localparam logic [11:0] WIN_BASE = 12'h058;

   localparam int MISC_COUNT = 5;

   localparam logic [11:0] OFF_START   = 12'h000;
   localparam logic [11:0] OFF_STOP    = 12'h004;
   localparam logic [11:0] OFF_CONTROL = 12'h008;
   localparam logic [11:0] OFF_FIFO    = 12'h00c;
   localparam logic [11:0] OFF_MASK    = 12'h014;
   localparam logic [11:0] OFF_STATUS  = 12'h018;
   localparam logic [11:0] OFF_MISC0   = 12'h01c;
   localparam logic [11:0] OFF_MISC1   = 12'h020;
   localparam logic [11:0] OFF_MISC2   = 12'h024;
   localparam logic [11:0] OFF_MISC3   = 12'h0d4;
   localparam logic [11:0] OFF_MISC4   = 12'h0e8;
   localparam logic [11:0] OFF_GATE    = 12'h200;
   localparam logic [11:0] OFF_HANDOFF = 12'h204;

   localparam logic [7:0] GATE_SEL_MASK    = 8'hc0;
   localparam logic [7:0] GATE_SEL_HANDOFF = 8'h40;

   // 33-bit dividend, one quotient bit per step
   localparam int DIV_STEPS = 33;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_TICK  = 2'd2,
      REQ_NOP   = 2'd3
   } req_kind_type;

   typedef enum logic {
      CSR_FRAME_PERIOD = 1'b0,
      CSR_HANDOFF      = 1'b1
   } csr_index_type;

   typedef enum logic {
      SEQ_IDLE   = 1'b0,
      SEQ_DIVIDE = 1'b1
   } seq_state_type;

   typedef struct packed {
      logic        en;
      logic [11:0] offset;
      logic [31:0] data;
   } wr_req_type;

   typedef struct packed {
      logic        en;
      logic [31:0] value;
      logic        set_status;
   } acc_upd_type;

   typedef struct packed {
      logic        tick_enable;
      logic [31:0] accumulator;
      logic [31:0] period;
      logic        irq;
   } reg_stat_type;

endpackage

FILE: rtl/lcdfi_divider.sv
// iterative restoring remainder unit, one bit per cycle
// depends on lcdfi_pkg
module lcdfi_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] remainder
);

   logic        busy_ff, busy_in;
   logic [lcdfi_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [32:0] dvd_ff, dvd_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [31:0] rem_ff, rem_in;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        last;

   assign trial = {rem_ff, dvd_ff[32]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign last  = busy_ff && (cnt_ff == lcdfi_pkg::DIV_CNT_W'(lcdfi_pkg::DIV_STEPS - 1));

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // partial remainder always stays below the divisor
         rem_in = (trial >= {1'b0, dsr_ff}) ? diff[31:0] : trial[31:0];
         dvd_in = {dvd_ff[31:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = last;
   assign remainder = rem_in;

endmodule

FILE: rtl/lcdfi_regs.sv
// register file: address decode, storage, read mux and frame accumulator
// depends on lcdfi_pkg
module lcdfi_regs (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [31:0]             csr_wdata,
   input  lcdfi_pkg::wr_req_type   wr,
   input  logic [11:0]             rd_offset,
   input  lcdfi_pkg::acc_upd_type  acc_upd,
   output logic [31:0]             rd_data,
   output lcdfi_pkg::reg_stat_type stat
);

   logic [31:0] period_ff, period_in;
   logic [31:0] handoff_ff, handoff_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] stop_ff, stop_in;
   logic [31:0] control_ff, control_in;
   logic [31:0] fifo_ff, fifo_in;
   logic [31:0] mask_ff, mask_in;
   logic        status_ff, status_in;
   logic [31:0] gate_ff, gate_in;
   logic        scan_ff, scan_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] misc_ff [lcdfi_pkg::MISC_COUNT];
   logic [31:0] misc_in [lcdfi_pkg::MISC_COUNT];
   logic [31:0] win_ff  [lcdfi_pkg::WIN_ENTRIES];
   logic [31:0] win_in  [lcdfi_pkg::WIN_ENTRIES];

   logic        wr_misc_hit, rd_misc_hit;
   logic [2:0]  wr_misc_idx, rd_misc_idx;
   logic        wr_win_hit, rd_win_hit;
   logic [lcdfi_pkg::WIN_IDX_W-1:0] wr_win_idx, rd_win_idx;

   function automatic logic [3:0] misc_decode(input logic [11:0] off);
      logic [3:0] r;
      case (off)
         lcdfi_pkg::OFF_MISC0: r = {1'b1, 3'd0};
         lcdfi_pkg::OFF_MISC1: r = {1'b1, 3'd1};
         lcdfi_pkg::OFF_MISC2: r = {1'b1, 3'd2};
         lcdfi_pkg::OFF_MISC3: r = {1'b1, 3'd3};
         lcdfi_pkg::OFF_MISC4: r = {1'b1, 3'd4};
         default:              r = 4'd0;
      endcase
      return r;
   endfunction

   // window k spans WIN_STRIDE bytes; the compare per window picks k
   function automatic logic [lcdfi_pkg::WIN_IDX_W:0] win_decode(input logic [11:0] off);
      logic [11:0] rel;
      logic [11:0] sub;
      logic [lcdfi_pkg::WIN_IDX_W-1:0] base;
      logic hit;
      rel  = off - lcdfi_pkg::WIN_BASE;
      sub  = rel;
      base = '0;
      hit  = 1'b0;
      for (int i = 0; i < lcdfi_pkg::WINDOW_COUNT; i++) begin
         if (rel >= 12'(i * lcdfi_pkg::WIN_STRIDE)) begin
            sub  = rel - 12'(i * lcdfi_pkg::WIN_STRIDE);
            base = lcdfi_pkg::WIN_IDX_W'(i * lcdfi_pkg::WIN_WORDS);
         end
      end
      if ((off >= lcdfi_pkg::WIN_BASE) && (rel < 12'(lcdfi_pkg::WIN_SPAN))
          && (sub[1:0] == 2'b00)) begin
         hit = 1'b1;
      end
      return {hit, base + lcdfi_pkg::WIN_IDX_W'(sub[4:2])};
   endfunction

   always_comb begin
      {wr_misc_hit, wr_misc_idx} = misc_decode(wr.offset);
      {rd_misc_hit, rd_misc_idx} = misc_decode(rd_offset);
      {wr_win_hit, wr_win_idx}   = win_decode(wr.offset);
      {rd_win_hit, rd_win_idx}   = win_decode(rd_offset);
   end

   always_comb begin
      period_in  = period_ff;
      handoff_in = handoff_ff;
      start_in   = start_ff;
      stop_in    = stop_ff;
      control_in = control_ff;
      fifo_in    = fifo_ff;
      mask_in    = mask_ff;
      status_in  = status_ff;
      gate_in    = gate_ff;
      scan_in    = scan_ff;
      acc_in     = acc_ff;
      misc_in    = misc_ff;
      win_in     = win_ff;

      if (csr_we) begin
         case (csr_index)
            lcdfi_pkg::CSR_FRAME_PERIOD: period_in  = csr_wdata;
            lcdfi_pkg::CSR_HANDOFF:      handoff_in = csr_wdata;
            default: ;
         endcase
      end

      if (acc_upd.en) begin
         acc_in = acc_upd.value;
         if (acc_upd.set_status) begin
            status_in = 1'b1;
         end
      end

      if (wr.en) begin
         case (wr.offset)
            lcdfi_pkg::OFF_START: begin
               start_in = wr.data;
               if (wr.data[0]) begin
                  scan_in = 1'b1;
                  acc_in  = '0;
               end
            end
            lcdfi_pkg::OFF_STOP: begin
               stop_in = wr.data;
               if (wr.data[0]) begin
                  scan_in = 1'b0;
               end
            end
            lcdfi_pkg::OFF_CONTROL: control_in = wr.data;
            lcdfi_pkg::OFF_FIFO:    fifo_in    = wr.data;
            lcdfi_pkg::OFF_MASK:    mask_in    = wr.data;
            lcdfi_pkg::OFF_STATUS: begin
               // write 1 to clear
               if (wr.data[0]) begin
                  status_in = 1'b0;
               end
            end
            lcdfi_pkg::OFF_GATE:    gate_in    = wr.data;
            lcdfi_pkg::OFF_HANDOFF: ;
            default: begin
               if (wr_misc_hit) begin
                  misc_in[wr_misc_idx] = wr.data;
               end else if (wr_win_hit) begin
                  win_in[wr_win_idx] = wr.data;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= '0;
         handoff_ff <= '0;
         start_ff   <= '0;
         stop_ff    <= '0;
         control_ff <= '0;
         fifo_ff    <= '0;
         mask_ff    <= '0;
         status_ff  <= 1'b0;
         gate_ff    <= '0;
         scan_ff    <= 1'b0;
         acc_ff     <= '0;
         for (int i = 0; i < lcdfi_pkg::MISC_COUNT; i++) begin
            misc_ff[i] <= '0;
         end
         for (int i = 0; i < lcdfi_pkg::WIN_ENTRIES; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         period_ff  <= period_in;
         handoff_ff <= handoff_in;
         start_ff   <= start_in;
         stop_ff    <= stop_in;
         control_ff <= control_in;
         fifo_ff    <= fifo_in;
         mask_ff    <= mask_in;
         status_ff  <= status_in;
         gate_ff    <= gate_in;
         scan_ff    <= scan_in;
         acc_ff     <= acc_in;
         misc_ff    <= misc_in;
         win_ff     <= win_in;
      end
   end

   always_comb begin
      case (rd_offset)
         lcdfi_pkg::OFF_START:   rd_data = start_ff;
         lcdfi_pkg::OFF_STOP:    rd_data = stop_ff;
         lcdfi_pkg::OFF_CONTROL: rd_data = control_ff;
         lcdfi_pkg::OFF_FIFO:    rd_data = fifo_ff;
         lcdfi_pkg::OFF_MASK:    rd_data = mask_ff;
         lcdfi_pkg::OFF_STATUS:  rd_data = {31'd0, status_ff};
         lcdfi_pkg::OFF_GATE:    rd_data = gate_ff;
         lcdfi_pkg::OFF_HANDOFF: begin
            rd_data = ((gate_ff[7:0] & lcdfi_pkg::GATE_SEL_MASK) == lcdfi_pkg::GATE_SEL_HANDOFF)
                      ? handoff_ff : 32'd0;
         end
         default: begin
            if (rd_misc_hit) begin
               rd_data = misc_ff[rd_misc_idx];
            end else if (rd_win_hit) begin
               rd_data = win_ff[rd_win_idx];
            end else begin
               rd_data = 32'd0;
            end
         end
      endcase
   end

   assign stat.tick_enable = scan_ff && control_ff[0] && gate_ff[0] && (period_ff != 32'd0);
   assign stat.accumulator = acc_ff;
   assign stat.period      = period_ff;
   assign stat.irq         = status_ff && mask_ff[0];

endmodule

FILE: rtl/lcd_controller_frame_interrupt_top.sv
// top level: item sequencer, result register, register file and remainder unit
// depends on lcdfi_pkg, lcdfi_regs and lcdfi_divider
//
// Register reads and writes, ticks that do not cross a frame boundary and ticks
// while the frame timer is off each have a valid result in the cycle after
// acceptance. A tick that brings the frame accumulator to or past the period
// waits for the remainder unit: the accumulator keeps the remainder of the
// 33-bit sum by the period, which the restoring remainder unit produces one
// bit per cycle; the input is not ready while it runs. One result register
// sits on the output, so a new item is taken in the cycle its predecessor's
// result is taken. irq_line shows latched frame status AND mask bit 0 after
// the item. There is no clearing pass after reset.
module lcd_controller_frame_interrupt_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // reg_offset[11:0], write_data[43:12], tick_count[75:44]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_data[31:0], irq_line[32]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   lcdfi_pkg::seq_state_type state_ff, state_in;
   lcdfi_pkg::req_kind_type  kind;
   lcdfi_pkg::wr_req_type    wr;
   lcdfi_pkg::acc_upd_type   acc_upd;
   lcdfi_pkg::reg_stat_type  stat;

   logic [11:0] offset;
   logic [31:0] write_data;
   logic [31:0] tick_count;
   logic        accept;
   logic        is_tick;
   logic [32:0] total;
   logic        need_div;
   logic        div_start;
   logic        div_done;
   logic [31:0] div_rem;
   logic [31:0] reg_rd;
   logic        rsp_load;
   logic [31:0] rsp_value;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   assign offset     = req_tdata[11:0];
   assign write_data = req_tdata[43:12];
   assign tick_count = req_tdata[75:44];
   assign kind       = lcdfi_pkg::req_kind_type'(req_tuser);

   assign accept   = req_tvalid && req_tready;
   assign is_tick  = (kind == lcdfi_pkg::REQ_TICK) && stat.tick_enable;
   assign total    = {1'b0, stat.accumulator} + {1'b0, tick_count};
   assign need_div = total >= {1'b0, stat.period};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcdfi_pkg::SEQ_IDLE: begin
            if (accept && is_tick && need_div) begin
               state_in = lcdfi_pkg::SEQ_DIVIDE;
            end
         end
         lcdfi_pkg::SEQ_DIVIDE: begin
            if (div_done) begin
               state_in = lcdfi_pkg::SEQ_IDLE;
            end
         end
         default: state_in = lcdfi_pkg::SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      div_start     = 1'b0;
      wr.en         = 1'b0;
      wr.offset     = offset;
      wr.data       = write_data;
      acc_upd.en    = 1'b0;
      acc_upd.value = total[31:0];
      acc_upd.set_status = 1'b0;
      rsp_load      = 1'b0;
      rsp_value     = 32'd0;
      case (state_ff)
         lcdfi_pkg::SEQ_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (accept) begin
               wr.en = (kind == lcdfi_pkg::REQ_WRITE);
               if (is_tick && need_div) begin
                  div_start = 1'b1;
               end else begin
                  acc_upd.en = is_tick;
                  rsp_load   = 1'b1;
                  rsp_value  = (kind == lcdfi_pkg::REQ_READ) ? reg_rd : 32'd0;
               end
            end
         end
         lcdfi_pkg::SEQ_DIVIDE: begin
            if (div_done) begin
               acc_upd.en         = 1'b1;
               acc_upd.value      = div_rem;
               acc_upd.set_status = 1'b1;
               rsp_load           = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_value;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcdfi_pkg::SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   lcdfi_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .wr        (wr),
      .rd_offset (offset),
      .acc_upd   (acc_upd),
      .rd_data   (reg_rd),
      .stat      (stat)
   );

   lcdfi_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (total),
      .divisor   (stat.period),
      .done      (div_done),
      .remainder (div_rem)
   );

   // state is frozen while a result waits, so irq can be taken live
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, stat.irq, rsp_data_ff};

endmodule
